[rtl/core/sip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_pkg
// Types, constants and character helpers shared by the string-to-integer
// parser unit.
// ----------------------------------------------------------------------------
package sip_pkg;

    localparam int unsigned OFFSET_WIDTH_DEF = 16;

    localparam int unsigned BASE_W   = 6;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned END_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OUT_W    = 88;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_BAD   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] DIGIT_NONE = 6'd36;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [END_W-1:0]   END_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_DONE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_PLUS   = 3'd2,
        PH_NUM    = 3'd3,
        PH_ZERO   = 3'd4,
        PH_PREFIX = 3'd5,
        PH_DIGITS = 3'd6,
        PH_SKIP   = 3'd7
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [BASE_W-1:0]  base;
        logic [BASE_W-1:0]  digit;
        logic               negative;
    } t_mac_in;

    typedef struct packed {
        logic [VALUE_W-1:0] sum;
        logic               overflow;
    } t_mac_out;

    function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
        logic [BASE_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 6'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = 6'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = 6'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

[rtl/core/string_to_integer_parser_unit.sv]
`timescale 1ns / 1ps
// Result path: the result word becomes valid on the master side once the terminating
//   character has passed from the input register into the result register.
// Throughput: one character per cycle; the 64x6 multiply-accumulate and range
//   compare sit between the input register and the parser state. A result word
//   held by the master side stalls the input.
// Reset: synchronous, active low; parser idle, number_base back to 10.
// ----------------------------------------------------------------------------
// string_to_integer_parser_unit
// Streaming string-to-integer parser: one character per word in, one
// value/offset/status word out per string at most.
// ----------------------------------------------------------------------------
module string_to_integer_parser_unit #(
    parameter int unsigned OFFSET_WIDTH = sip_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [sip_pkg::BASE_W-1:0] i_cfg_data,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,  // [7:0] ch
    input  logic                       i_s_axis_tuser,  // [0] first
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [sip_pkg::OUT_W-1:0]  o_m_axis_tdata   // [63:0] value, [79:64] end_offset,
                                                        // [81:80] status, [87:82] zero
);
    import sip_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0] POS_MAX = {OFFSET_WIDTH{1'b1}};

    logic                    r_cfg_base;
    logic [BASE_W-1:0]       r_number_base;

    logic                    r_in_valid;
    logic [7:0]              r_ch;
    logic                    r_first;

    t_phase                  r_phase, n_phase;
    logic [VALUE_W-1:0]      r_acc, n_acc;
    logic                    r_neg, n_neg;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    logic [BASE_W-1:0]       r_base, n_base;

    logic                    r_out_valid;
    logic [VALUE_W-1:0]      r_out_value, n_out_value;
    logic [END_W-1:0]        r_out_end, n_out_end;
    t_status                 r_out_status, n_out_status;

    logic                    fire;
    logic                    emit;
    logic [BASE_W-1:0]       dig;
    logic [31:0]             pos_ext;
    t_mac_in                 mac_req;
    t_mac_out                mac_rsp;

    assign r_cfg_base = i_cfg_valid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RESET;
        end else if (r_cfg_base) begin
            r_number_base <= i_cfg_data;
        end
    end

    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_ch    <= i_s_axis_tdata;
            r_first <= i_s_axis_tuser;
        end
    end

    assign dig              = digit_of(r_ch);
    assign mac_req.acc      = (r_phase == PH_ZERO) ? '0 : r_acc;
    assign mac_req.base     = (r_base == BASE_AUTO) ? BASE_OCT : r_base;
    assign mac_req.digit    = dig;
    assign mac_req.negative = r_neg;

    sip_mac_unit u_mac (
        .i_req (mac_req),
        .o_rsp (mac_rsp)
    );

    always_comb begin
        t_phase                  e_ph;
        logic [VALUE_W-1:0]      e_acc;
        logic                    e_neg;
        logic [OFFSET_WIDTH-1:0] e_pos;
        logic [BASE_W-1:0]       e_base;
        logic                    run;
        logic                    do_start;
        logic                    do_digits;
        logic [VALUE_W-1:0]      e_val;
        t_status                 e_st;

        e_ph      = r_phase;
        e_acc     = r_acc;
        e_neg     = r_neg;
        e_pos     = r_pos;
        e_base    = r_base;
        run       = 1'b1;
        do_start  = 1'b0;
        do_digits = 1'b0;
        emit      = 1'b0;
        e_val     = '0;
        e_st      = ST_OK;

        if (r_first) begin
            e_acc  = '0;
            e_neg  = 1'b0;
            e_pos  = '0;
            e_base = r_number_base;
            e_ph   = PH_LEAD;
            if (r_number_base == BASE_BAD || r_number_base > BASE_MAX) begin
                emit = 1'b1;
                e_st = ST_INVALID;
                run  = 1'b0;
            end
        end else if (r_phase == PH_DONE) begin
            run = 1'b0;
        end

        n_phase = e_ph;
        n_acc   = e_acc;
        n_neg   = e_neg;
        n_base  = e_base;

        if (run) begin
            case (e_ph)
                PH_LEAD: begin
                    if (is_space(r_ch)) begin
                        n_phase = PH_LEAD;
                    end else if (r_ch == CH_PLUS) begin
                        n_phase = PH_PLUS;
                    end else if (r_ch == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_NUM;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                PH_PLUS: begin
                    if (r_ch == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_NUM;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                PH_NUM: begin
                    do_start = 1'b1;
                end
                PH_ZERO: begin
                    if (r_ch == CH_X) begin
                        n_base  = BASE_HEX;
                        n_phase = PH_PREFIX;
                    end else begin
                        if (e_base == BASE_AUTO) begin
                            n_base = BASE_OCT;
                        end
                        n_acc     = '0;
                        n_phase   = PH_DIGITS;
                        do_digits = 1'b1;
                    end
                end
                PH_PREFIX: begin
                    if (dig >= e_base) begin
                        emit = 1'b1;
                        e_st = ST_INVALID;
                    end else begin
                        n_acc   = {{(VALUE_W - BASE_W){1'b0}}, dig};
                        n_phase = PH_DIGITS;
                    end
                end
                PH_DIGITS: begin
                    do_digits = 1'b1;
                end
                PH_SKIP: begin
                    if (r_ch == CH_NUL) begin
                        emit  = 1'b1;
                        e_st  = ST_RANGE;
                        e_val = e_neg ? NEG_LIMIT : POS_LIMIT;
                    end
                end
                default: begin
                    n_phase = e_ph;
                end
            endcase

            if (do_start) begin
                if ((e_base == BASE_AUTO || e_base == BASE_HEX) && r_ch == CH_ZERO) begin
                    n_phase = PH_ZERO;
                end else begin
                    if (e_base == BASE_AUTO) begin
                        n_base = BASE_DEC;
                    end
                    if (dig >= n_base) begin
                        emit = 1'b1;
                        e_st = ST_INVALID;
                    end else begin
                        n_acc   = {{(VALUE_W - BASE_W){1'b0}}, dig};
                        n_phase = PH_DIGITS;
                    end
                end
            end

            if (do_digits) begin
                if (dig >= mac_req.base) begin
                    emit  = 1'b1;
                    e_st  = ST_OK;
                    e_val = e_neg ? (VALUE_W'(0) - n_acc) : n_acc;
                end else if (mac_rsp.overflow) begin
                    n_phase = PH_SKIP;
                end else begin
                    n_acc = mac_rsp.sum;
                end
            end
        end

        if (emit) begin
            n_phase = PH_DONE;
        end

        n_pos = e_pos;
        if (run && !emit && e_pos != POS_MAX) begin
            n_pos = e_pos + 1'b1;
        end

        pos_ext      = 32'(e_pos);
        n_out_end    = (pos_ext > 32'(END_MAX)) ? END_MAX : pos_ext[END_W-1:0];
        n_out_value  = e_val;
        n_out_status = e_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_pos   <= '0;
            r_base  <= BASE_RESET;
        end else if (fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_pos   <= n_pos;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_value  <= n_out_value;
            r_out_end    <= n_out_end;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W - VALUE_W - END_W - STATUS_W){1'b0}},
                              r_out_status, r_out_end, r_out_value};

    a_no_drop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_s_axis_tready) |-> (r_in_valid && r_out_valid))
        else $error("input held without a pending result");

    a_range_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_RANGE) |->
        (r_out_value == POS_LIMIT || r_out_value == NEG_LIMIT))
        else $error("range result not saturated");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_INVALID) |-> (r_out_value == '0))
        else $error("invalid result carries a value");

    a_skip_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_phase == PH_SKIP && !r_first && r_ch != CH_NUL) |=>
        (r_phase == PH_SKIP))
        else $error("overflow skip left before end of string");

    a_emit_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && emit) |=> (r_phase == PH_DONE && r_out_valid))
        else $error("result issued without returning to idle");

endmodule

[rtl/core/sip_mac_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_mac_unit
// Multiply-accumulate of one digit into the magnitude with exact range check
// against the signed 64-bit limit.
// ----------------------------------------------------------------------------
module sip_mac_unit (
    input  sip_pkg::t_mac_in  i_req,
    output sip_pkg::t_mac_out o_rsp
);
    import sip_pkg::*;

    logic [VALUE_W+BASE_W-1:0] prod;
    logic [VALUE_W+BASE_W:0]   sum;
    logic [VALUE_W-1:0]        limit;

    assign prod  = {{BASE_W{1'b0}}, i_req.acc} * {{VALUE_W{1'b0}}, i_req.base};
    assign sum   = {1'b0, prod} + {{(VALUE_W + 1){1'b0}}, i_req.digit};
    assign limit = i_req.negative ? NEG_LIMIT : POS_LIMIT;

    assign o_rsp.sum      = sum[VALUE_W-1:0];
    assign o_rsp.overflow = sum > {{(BASE_W + 1){1'b0}}, limit};

endmodule

[tb/parse_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parse_result_checker
// Watches the configuration, character and result channels of the string
// parser, keeps its own model of the parse state, and compares every result
// word against the oldest predicted parse. Hands the failure count and the
// number of outstanding predictions to the testbench top.
// ----------------------------------------------------------------------------
module parse_result_checker #(
    parameter int unsigned OFFSET_WIDTH = sip_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [sip_pkg::BASE_W-1:0] i_cfg_data,
    input  logic                       i_s_axis_tvalid,
    input  logic                       i_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,   // [7:0] ch
    input  logic                       i_s_axis_tuser,   // [0] first
    input  logic                       i_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    input  logic [sip_pkg::OUT_W-1:0]  i_m_axis_tdata,   // [63:0] value, [79:64] end_offset,
                                                         // [81:80] status, [87:82] zero
    output int                         o_fail_count,
    output int                         o_pending
);
    import sip_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [END_W-1:0]   end_offset;
        t_status            status;
    } t_parse_result;

    localparam logic [32:0] POSITION_MAX = (33'd1 << OFFSET_WIDTH) - 33'd1;

    logic [BASE_W-1:0]  base_reg    = BASE_RESET;
    logic [BASE_W-1:0]  active_base = BASE_DEC;
    t_phase             phase       = PH_DONE;
    logic [VALUE_W-1:0] accum       = '0;
    logic               negative    = 1'b0;
    logic [32:0]        position    = '0;
    t_parse_result      expected_parses[$];
    int                 errors      = 0;

    function automatic logic [BASE_W-1:0] char_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return 6'(c - 8'h30);
        end
        if (c >= 8'h61 && c <= 8'h7A) begin
            return 6'(c - 8'h57);
        end
        if (c >= 8'h41 && c <= 8'h5A) begin
            return 6'(c - 8'h37);
        end
        return DIGIT_NONE;
    endfunction

    function automatic void post_result(input logic [VALUE_W-1:0] v, input t_status s);
        t_parse_result r;
        r.value      = v;
        r.end_offset = (position > 33'(END_MAX)) ? END_MAX : position[END_W-1:0];
        r.status     = s;
        expected_parses.push_back(r);
        phase = PH_DONE;
    endfunction

    function automatic void digit_step(input logic [7:0] c);
        logic [BASE_W-1:0]  d;
        logic [VALUE_W-1:0] limit;
        d = char_value(c);
        if (d >= active_base) begin
            post_result(negative ? 64'd0 - accum : accum, ST_OK);
            return;
        end
        limit = negative ? NEG_LIMIT : POS_LIMIT;
        if (accum > (limit - 64'(d)) / 64'(active_base)) begin
            phase = PH_SKIP;
        end else begin
            accum = accum * 64'(active_base) + 64'(d);
        end
    endfunction

    function automatic void number_start(input logic [7:0] c);
        logic [BASE_W-1:0] d;
        if ((active_base == BASE_AUTO || active_base == BASE_HEX) && c == CH_ZERO) begin
            phase = PH_ZERO;
            return;
        end
        if (active_base == BASE_AUTO) begin
            active_base = BASE_DEC;
        end
        d = char_value(c);
        if (d >= active_base) begin
            post_result('0, ST_INVALID);
        end else begin
            accum = 64'(d);
            phase = PH_DIGITS;
        end
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic first);
        logic [BASE_W-1:0] d;
        logic              blank;
        if (first) begin
            accum       = '0;
            negative    = 1'b0;
            position    = '0;
            active_base = base_reg;
            phase       = PH_LEAD;
            if (active_base == BASE_BAD || active_base > BASE_MAX) begin
                post_result('0, ST_INVALID);
                return;
            end
        end else if (phase == PH_DONE) begin
            return;
        end
        blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        case (phase)
            PH_LEAD: begin
                if (!blank) begin
                    if (c == CH_PLUS) begin
                        phase = PH_PLUS;
                    end else if (c == CH_MINUS) begin
                        negative = 1'b1;
                        phase    = PH_NUM;
                    end else begin
                        number_start(c);
                    end
                end
            end
            PH_PLUS: begin
                if (c == CH_MINUS) begin
                    negative = 1'b1;
                    phase    = PH_NUM;
                end else begin
                    number_start(c);
                end
            end
            PH_NUM: begin
                number_start(c);
            end
            PH_ZERO: begin
                if (c == CH_X) begin
                    active_base = BASE_HEX;
                    phase       = PH_PREFIX;
                end else begin
                    if (active_base == BASE_AUTO) begin
                        active_base = BASE_OCT;
                    end
                    accum = '0;
                    phase = PH_DIGITS;
                    digit_step(c);
                end
            end
            PH_PREFIX: begin
                d = char_value(c);
                if (d >= active_base) begin
                    post_result('0, ST_INVALID);
                end else begin
                    accum = 64'(d);
                    phase = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                digit_step(c);
            end
            PH_SKIP: begin
                if (c == CH_NUL) begin
                    post_result(negative ? NEG_LIMIT : POS_LIMIT, ST_RANGE);
                end
            end
            default: begin
            end
        endcase
        if (phase != PH_DONE && position < POSITION_MAX) begin
            position = position + 33'd1;
        end
    endfunction

    function automatic void report_failure(input string what, input t_parse_result want,
                                           input logic [OUT_W-1:0] word);
        errors++;
        if (errors <= 10) begin
            $display("%s: expected value %0d end %0d status %0d, got value %0d end %0d status %0d pad %0h",
                     what, $signed(want.value), want.end_offset, want.status,
                     $signed(word[63:0]), word[79:64], word[81:80], word[87:82]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_parse_result want;
        if (!i_rst_n) begin
            base_reg    = BASE_RESET;
            active_base = BASE_DEC;
            phase       = PH_DONE;
            accum       = '0;
            negative    = 1'b0;
            position    = '0;
            expected_parses.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_parses.size() == 0) begin
                    want = '0;
                    report_failure("unexpected word", want, i_m_axis_tdata);
                end else begin
                    want = expected_parses.pop_front();
                    if (i_m_axis_tdata[63:0] != want.value
                            || i_m_axis_tdata[79:64] != want.end_offset
                            || i_m_axis_tdata[81:80] != want.status
                            || i_m_axis_tdata[87:82] != '0) begin
                        report_failure("mismatch", want, i_m_axis_tdata);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                base_reg = i_cfg_data;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                parse_char(i_s_axis_tdata, i_s_axis_tuser);
            end
        end
        o_pending    <= expected_parses.size();
        o_fail_count <= errors;
    end

endmodule

[tb/tb_string_to_integer_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_to_integer_parser_unit
// Drives NUL-terminated strings into the parser under all radix settings:
// a directed set of boundary and corner strings, then mostly well-formed
// random numbers mixed with noise, restarts and stray characters, and one
// overflowing string with a long tail. Both stream sides stall at random;
// a side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_string_to_integer_parser_unit;
    import sip_pkg::*;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [BASE_W-1:0] cfg_data  = BASE_RESET;
    logic              s_tvalid  = 1'b0;
    logic [7:0]        s_tdata   = CH_NUL;
    logic              s_tuser   = 1'b0;
    logic              m_tready  = 1'b0;
    logic              cfg_ready;
    logic              s_tready;
    logic              m_tvalid;
    logic [OUT_W-1:0]  m_tdata;
    int                fail_count;
    int                pending;
    bit                quiet      = 1'b0;
    int                chars_sent = 0;

    always #2 clk = ~clk;

    string_to_integer_parser_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    parse_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    function automatic int gap_len();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic first);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_str(input string s, input bit add_nul = 1'b1);
        foreach (s[i]) begin
            send_char(s[i], i == 0);
        end
        if (add_nul) begin
            send_char(CH_NUL, s.len() == 0);
        end
    endtask

    // hold off until every predicted word is out and the pipeline has drained
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= b;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BASE_W-1:0] pick_base();
        case ($urandom_range(0, 9))
            0, 8:    return BASE_AUTO;
            1:       return BASE_DEC;
            2:       return BASE_HEX;
            3:       return 6'd2;
            4:       return BASE_OCT;
            5:       return BASE_MAX;
            7:       return ($urandom_range(0, 1) == 0) ? BASE_BAD : 6'($urandom_range(37, 63));
            default: return 6'($urandom_range(2, 36));
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) begin
            return 8'(8'h30 + d);
        end
        return 8'((($urandom_range(0, 1) == 0) ? 8'h61 : 8'h41) + d - 10);
    endfunction

    task automatic send_random_string(input logic [BASE_W-1:0] base);
        logic [7:0] text[$];
        int         radix;
        int         n;
        int         w;
        int         term;
        radix = (base >= 6'd2 && base <= BASE_MAX) ? int'(base) : 10;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    w = $urandom_range(8, 13);
                    text.push_back((w == 8) ? CH_SPACE : 8'(w));
                end
            end
            if ($urandom_range(0, 3) == 0) text.push_back(CH_PLUS);
            if ($urandom_range(0, 2) == 0) text.push_back(CH_MINUS);
            if (base == BASE_AUTO) begin
                case ($urandom_range(0, 2))
                    0: begin
                        text.push_back(CH_ZERO);
                        text.push_back(CH_X);
                        radix = 16;
                    end
                    1: begin
                        text.push_back(CH_ZERO);
                        radix = 8;
                    end
                    default: radix = 10;
                endcase
            end else if (base == BASE_HEX && $urandom_range(0, 2) == 0) begin
                text.push_back(CH_ZERO);
                text.push_back(CH_X);
            end
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(15, 70);
                1:       n = 0;
                default: n = $urandom_range(1, 8);
            endcase
            repeat (n) text.push_back(digit_char($urandom_range(0, radix - 1)));
            term = $urandom_range(0, 9);
            if (term == 7 || term == 8) text.push_back(8'($urandom_range(1, 255)));
            if (term <= 7) text.push_back(CH_NUL);
        end
        foreach (text[i]) begin
            send_char(text[i], i == 0);
        end
        chars_sent += text.size();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial begin
        int gap;
        @(posedge clk);
        forever begin
            gap = gap_len();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [BASE_W-1:0] base;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_str(" \t+-42");
        send_str("9223372036854775807");
        send_str("-9223372036854775808");
        send_str("9223372036854775808");
        send_str("-9223372036854775809x");
        send_str("-+7");
        send_str("abc");
        send_str("");
        send_str("12a");
        send_str("34", 1'b0);
        send_char(8'h0B, 1'b1);
        send_char(8'h0C, 1'b0);
        send_char(8'h0A, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char("8", 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char("5", 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b1);

        write_base(BASE_AUTO);
        send_str("0x1F");
        send_str("017");
        send_str("0x");
        send_str("0X1");
        send_str("-0");
        send_str("99");
        write_base(BASE_HEX);
        send_str("0xfF");
        send_str("-0x");
        send_str("-8000000000000000");
        send_str("8000000000000000");
        write_base(BASE_MAX);
        send_str("Zz");
        write_base(6'd2);
        send_str("1012");
        write_base(BASE_BAD);
        send_str("1");
        write_base(6'd63);
        send_str("7");

        while (chars_sent < 250) begin
            base = pick_base();
            write_base(base);
            quiet = ($urandom_range(0, 7) == 0);
            repeat ($urandom_range(3, 8)) send_random_string(base);
        end
        quiet = 1'b0;

        // overflow followed by a long tail of digits
        write_base(BASE_DEC);
        quiet = 1'b1;
        send_char("9", 1'b1);
        repeat (19) send_char("9", 1'b0);
        repeat (40) send_char("1", 1'b0);
        send_char(CH_NUL, 1'b0);
        quiet = 1'b0;

        settle();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
